[rtl/rar_pkg.sv]
// Package for the rational arithmetic reducer: word width, operation codes,
// and the controller/datapath command and status structs. No dependencies.
package rar_pkg;
	localparam int WORD_BITS = 32;
	localparam int FIELD_BITS = 32;
	localparam int CNT_BITS = $clog2(WORD_BITS + 1);

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture operands
		logic prod;      // register cross products
		logic combine;   // form n and d, set up x = n, y = d
		logic div_start; // start one magnitude division
		logic div_sel;   // 0: x rem y, or n by g once y is zero; 1: d by g
		logic div_step;  // one restoring step
		logic gcd_next;  // x = y, y = rem
		logic qn_take;   // store n/g
		logic qd_take;   // d/g done; quotient stays in the divider
		logic fin;       // write result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic y_zero;
		logic x_zero;
		logic div_done;
	} stat_t;
endpackage

[rtl/rar_ctrl.sv]
// Controller state machine for the rational arithmetic reducer.
// Depends on rar_pkg.
module rar_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	output logic           in_free,
	input  logic           out_busy,
	input  rar_pkg::stat_t stat,
	output rar_pkg::cmd_t  cmd
);
	import rar_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PROD, S_COMB, S_TEST, S_REM, S_QN0, S_QN, S_QD0, S_QD, S_OUT
	} state_t;

	state_t state_q;

	assign in_free = (state_q == S_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		case (state_q)
			S_PROD: cmd.prod = 1'b1;
			S_COMB: cmd.combine = 1'b1;
			S_TEST: begin
				if (!stat.y_zero) begin
					cmd.div_start = 1'b1;
				end
			end
			S_REM: begin
				cmd.div_step = !stat.div_done;
				cmd.gcd_next = stat.div_done;
			end
			S_QN0: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b0;
			end
			S_QN: begin
				cmd.div_step = !stat.div_done;
				cmd.qn_take = stat.div_done;
			end
			S_QD0: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
			end
			S_QD: begin
				cmd.div_step = !stat.div_done;
				cmd.qd_take = stat.div_done;
			end
			S_OUT: cmd.fin = !out_busy;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_PROD;
				S_PROD: state_q <= S_COMB;
				S_COMB: state_q <= S_TEST;
				S_TEST: begin
					if (!stat.y_zero) state_q <= S_REM;
					else if (stat.x_zero) state_q <= S_OUT;
					else state_q <= S_QN0;
				end
				S_REM: if (stat.div_done) state_q <= S_TEST;
				S_QN0: state_q <= S_QN;
				S_QN: if (stat.div_done) state_q <= S_QD0;
				S_QD0: state_q <= S_QD;
				S_QD: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE)
		else $error("item accepted while busy");
	a_fin_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> state_q == S_IDLE)
		else $error("finish did not return to idle");
	a_one_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !cmd.div_step)
		else $error("divider start and step together");
endmodule

[rtl/rar_datapath.sv]
// Datapath for the rational arithmetic reducer: operand registers, cross
// products, gcd registers and a shared restoring divider. Depends on rar_pkg.
module rar_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          operation,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] a_num,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] a_den,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] b_num,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] b_den,
	input  rar_pkg::cmd_t                       cmd,
	output rar_pkg::stat_t                      stat,
	output logic signed [rar_pkg::FIELD_BITS-1:0] res_num,
	output logic signed [rar_pkg::FIELD_BITS-1:0] res_den,
	output logic                                zero_gcd_error,
	output logic                                res_valid,
	input  logic                                res_taken
);
	import rar_pkg::*;

	localparam int W = WORD_BITS;

	op_t   op_q;
	word_t an_q, ad_q, bn_q, bd_q;
	word_t p1_q, p2_q, pd_q;
	word_t n_q, d_q, x_q, y_q, qn_q;
	logic [W-1:0]        dvd_q, dvs_q, rem_q, quo_q;
	logic                neg_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;

	// sign-extend or wrap a field to the word
	function automatic word_t from_field(input logic [FIELD_BITS-1:0] v);
		logic [W+FIELD_BITS-1:0] e;
		e = {{W{v[FIELD_BITS-1]}}, v};
		return word_t'(e[W-1:0]);
	endfunction

	function automatic logic [W-1:0] mag(input word_t v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic [FIELD_BITS-1:0] to_field(input word_t v);
		logic [W+FIELD_BITS-1:0] e;
		e = {{FIELD_BITS{v[W-1]}}, v};
		return e[FIELD_BITS-1:0];
	endfunction

	// one restoring step
	logic [W:0] trial;
	assign trial = {rem_q, dvd_q[W-1]} - {1'b0, dvs_q};

	assign stat.y_zero = (y_q == '0);
	assign stat.x_zero = (x_q == '0);
	assign stat.div_done = busy_q && (cnt_q == CNT_BITS'(W));

	word_t q_signed;
	assign q_signed = neg_q ? word_t'(-quo_q) : word_t'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (cmd.div_start) busy_q <= 1'b1;
			else if (stat.div_done) busy_q <= 1'b0;
			if (cmd.fin) res_valid <= 1'b1;
			else if (res_taken) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(operation);
			an_q <= from_field(a_num);
			ad_q <= from_field(a_den);
			bn_q <= from_field(b_num);
			bd_q <= from_field(b_den);
		end
		// cross products, wrapped to the word
		if (cmd.prod) begin
			p1_q <= (op_q == OP_MUL) ? word_t'(an_q * bn_q) : word_t'(an_q * bd_q);
			p2_q <= word_t'(bn_q * ad_q);
			pd_q <= (op_q == OP_DIV) ? word_t'(ad_q * bn_q) : word_t'(ad_q * bd_q);
		end
		if (cmd.combine) begin
			case (op_q)
				OP_ADD: n_q <= p1_q + p2_q;
				OP_SUB: n_q <= p1_q - p2_q;
				default: n_q <= p1_q;
			endcase
			d_q <= pd_q;
			x_q <= (op_q == OP_ADD) ? p1_q + p2_q : (op_q == OP_SUB) ? p1_q - p2_q : p1_q;
			y_q <= pd_q;
		end
		// divider start: rem mode divides x by y, quotient mode by g = x
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			if (cmd.div_sel) begin
				dvd_q <= mag(d_q);
				dvs_q <= mag(x_q);
				neg_q <= d_q[W-1] ^ x_q[W-1];
			end else if (y_q != '0) begin
				dvd_q <= mag(x_q);
				dvs_q <= mag(y_q);
				neg_q <= x_q[W-1];
			end else begin
				dvd_q <= mag(n_q);
				dvs_q <= mag(x_q);
				neg_q <= n_q[W-1] ^ x_q[W-1];
			end
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		// gcd step: remainder takes the dividend's sign
		if (cmd.gcd_next) begin
			x_q <= y_q;
			y_q <= neg_q ? word_t'(-rem_q) : word_t'(rem_q);
		end
		if (cmd.qn_take) qn_q <= q_signed;
		// qd result kept in quo/neg until finish
		if (cmd.fin) begin
			zero_gcd_error <= (x_q == '0);
			res_num <= (x_q == '0) ? '0 : to_field(qn_q);
			res_den <= (x_q == '0) ? '0 : to_field(q_signed);
		end
		if (cmd.qd_take) qn_q <= qn_q;
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> busy_q && cnt_q == '0)
		else $error("divider did not start");
	a_gcd_nz: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_next |-> !stat.y_zero)
		else $error("remainder by zero");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (zero_gcd_error |-> res_num == '0 && res_den == '0))
		else $error("error result not zero");
endmodule

[rtl/rational_arith_reduce.sv]
// Top level of the rational arithmetic reducer: ties controller to datapath.
// Depends on rar_pkg, rar_ctrl and rar_datapath.
//
//  channel  dir  tdata fields (low bit up)                         tuser
//  s_axis   in   a_num, a_den, b_num, b_den                        operation
//  m_axis   out  res_num, res_den                                  zero_gcd_error
//
// One item at a time: setup through the product and combine states, then per
// Euclid step a start and a full run of the shared restoring divider, then two
// quotient divisions and the output state; a zero-over-zero item skips the quotients.
// Reset clears the controller and valid flags.
// A stalled output holds the result while the next item is taken and worked
// on; that item then waits in the output cycle until the result is sent.
module rational_arith_reduce (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
	input  logic [1:0]   s_axis_tuser,  // operation
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // res_num, res_den
	output logic         m_axis_tuser   // zero_gcd_error
);
	import rar_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_free;
	logic signed [FIELD_BITS-1:0] rn, rd;

	assign s_axis_tready = in_free;

	rar_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.in_free(in_free),
		.out_busy(m_axis_tvalid && !m_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	rar_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.operation(s_axis_tuser),
		.a_num(s_axis_tdata[31:0]), .a_den(s_axis_tdata[63:32]),
		.b_num(s_axis_tdata[95:64]), .b_den(s_axis_tdata[127:96]),
		.cmd(cmd), .stat(stat),
		.res_num(rn), .res_den(rd), .zero_gcd_error(m_axis_tuser),
		.res_valid(m_axis_tvalid), .res_taken(m_axis_tready)
	);

	assign m_axis_tdata = {rd, rn};
endmodule
